@@ sv/olist_pkg.sv @@
// Ordered list engine: shared types and codes.
// No dependencies; imported by the interfaces' users, the cells, the control and the top level.
`default_nettype none

package olist_pkg;

    // request action codes
    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_FIND   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } olist_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    // broadcast from the control to every cell
    typedef struct packed {
        cell_op_t op;     // entry update, applied on commit
        logic     clear;  // drop the carry chain
        logic     scan;   // advance the carry chain one cell
        logic     find;   // scan matches on value instead of index
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/olist_ifs.sv @@
// Ordered list engine: request and response channel interfaces.
// Valid/ready handshake; widths are set by the instantiating level.
`default_nettype none

interface olist_req_if #(
    parameter int PW        = 7,
    parameter int WORD_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           action;
    logic [PW-1:0]        position;
    logic [WORD_BITS-1:0] word_in;

    modport source (output valid, action, position, word_in, input ready);
    modport sink   (input valid, action, position, word_in, output ready);
endinterface

interface olist_rsp_if #(
    parameter int IW        = 6,
    parameter int PW        = 7,
    parameter int WORD_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] word_out;
    logic [IW-1:0]        found_index;
    logic [PW-1:0]        length;
    logic [1:0]           status;

    modport source (output valid, word_out, found_index, length, status, input ready);
    modport sink   (input valid, word_out, found_index, length, status, output ready);
endinterface

`default_nettype wire

@@ sv/ordered_list_engine_top.sv @@
// Ordered list engine top level: a row of list cells and the request sequencer.
// Depends on olist_pkg, olist_ifs.sv, olist_cell and olist_ctrl.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+----------------------------------------------
//  req     | in  | valid / ready  | action, position, word_in
//  rsp     | out | valid / ready  | word_out, found_index, length, status
//
// Each request is accepted, then runs n carry-chain steps, then commits into
// the response register. n is 0 for append, insert, unused actions
// and out-of-range requests, position + 1 for read and delete, and the current
// length for find; the carry chain moves one cell per cycle toward cell 0.
// Reset (rst_n low, asynchronous) empties the list; entry contents are not cleared.
// A new request is taken while the previous response still waits; a stalled
// response holds the next request in its commit cycle until rsp drains.
`default_nettype none

module ordered_list_engine_top
    import olist_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    olist_req_if.sink   req,
    olist_rsp_if.source rsp
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    cell_cmd_t            cmd;
    logic [PW-1:0]        cell_pos;
    logic [WORD_BITS-1:0] cell_word;

    // cell k drives entry slot k+1; slots 0 and DEPTH+1 are fixed zero edges
    logic [WORD_BITS-1:0] entry_w [DEPTH+2];
    // cell k drives carry slot k; slot DEPTH is the empty top of the chain
    logic                 hit_w   [DEPTH+1];
    logic [WORD_BITS-1:0] cword_w [DEPTH+1];
    logic [IW-1:0]        cidx_w  [DEPTH+1];

    assign entry_w[0]       = '0;
    assign entry_w[DEPTH+1] = '0;
    assign hit_w[DEPTH]     = 1'b0;
    assign cword_w[DEPTH]   = '0;
    assign cidx_w[DEPTH]    = '0;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        olist_cell #(
            .INDEX     (k),
            .DEPTH     (DEPTH),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .pos        (cell_pos),
            .word_in    (cell_word),
            .lower_data (entry_w[k]),
            .upper_data (entry_w[k+2]),
            .upper_hit  (hit_w[k+1]),
            .upper_word (cword_w[k+1]),
            .upper_idx  (cidx_w[k+1]),
            .data       (entry_w[k+1]),
            .hit        (hit_w[k]),
            .carry_word (cword_w[k]),
            .carry_idx  (cidx_w[k])
        );
    end

    olist_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cmd        (cmd),
        .cell_pos   (cell_pos),
        .cell_word  (cell_word),
        .carry_hit  (hit_w[0]),
        .carry_word (cword_w[0]),
        .carry_idx  (cidx_w[0])
    );

endmodule

`default_nettype wire

@@ sv/olist_cell.sv @@
// Ordered list engine: one list cell (entry register plus one carry stage).
// Depends on olist_pkg.
`default_nettype none

module olist_cell
    import olist_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cell_cmd_t                    cmd,
    input  wire logic [$clog2(DEPTH+1)-1:0]   pos,
    input  wire logic [WORD_BITS-1:0]         word_in,
    input  wire logic [WORD_BITS-1:0]         lower_data,
    input  wire logic [WORD_BITS-1:0]         upper_data,
    input  wire logic                         upper_hit,
    input  wire logic [WORD_BITS-1:0]         upper_word,
    input  wire logic [$clog2(DEPTH)-1:0]     upper_idx,
    output logic      [WORD_BITS-1:0]         data,
    output logic                              hit,
    output logic      [WORD_BITS-1:0]         carry_word,
    output logic      [$clog2(DEPTH)-1:0]     carry_idx
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [PW-1:0] MY_POS = PW'(INDEX);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 hit_reg;
    logic [WORD_BITS-1:0] cword_reg;
    logic [IW-1:0]        cidx_reg;
    logic                 sel;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (MY_POS > pos)
                    data_next = lower_data;
                else if (MY_POS == pos)
                    data_next = word_in;
            end
            CELL_DELETE:
            begin
                if (MY_POS >= pos)
                    data_next = upper_data;
            end
            default: data_next = data_reg;
        endcase
    end

    assign sel = cmd.find ? (data_reg == word_in) : (MY_POS == pos);

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // carry stage: lowest selected cell wins once the chain has run far enough
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (cmd.clear)
            hit_reg <= 1'b0;
        else if (cmd.scan)
            hit_reg <= sel | upper_hit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            if (sel)
            begin
                cword_reg <= data_reg;
                cidx_reg  <= MY_IDX;
            end
            else
            begin
                cword_reg <= upper_word;
                cidx_reg  <= upper_idx;
            end
        end
    end

    assign data       = data_reg;
    assign hit        = hit_reg;
    assign carry_word = cword_reg;
    assign carry_idx  = cidx_reg;

endmodule

`default_nettype wire

@@ sv/olist_ctrl.sv @@
// Ordered list engine: request sequencer, length counter and response register.
// Depends on olist_pkg and the channel interfaces in olist_ifs.sv.
`default_nettype none

module olist_ctrl
    import olist_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    olist_req_if.sink                         req,
    olist_rsp_if.source                       rsp,
    output cell_cmd_t                         cmd,
    output logic      [$clog2(DEPTH+1)-1:0]   cell_pos,
    output logic      [WORD_BITS-1:0]         cell_word,
    input  wire logic                         carry_hit,
    input  wire logic [WORD_BITS-1:0]         carry_word,
    input  wire logic [$clog2(DEPTH)-1:0]     carry_idx
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [PW-1:0] FULL_COUNT = PW'(DEPTH);

    olist_state_t         state_reg, state_next;
    logic [2:0]           act_reg;
    logic [PW-1:0]        pos_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [PW-1:0]        count_reg, count_next;
    logic [PW-1:0]        left_reg;
    logic [PW-1:0]        scan_n;
    logic                 accept;
    logic                 commit;

    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_word_reg;
    logic [IW-1:0]        out_idx_reg;
    logic [PW-1:0]        out_len_reg;
    logic [1:0]           out_status_reg;

    logic [WORD_BITS-1:0] res_word;
    logic [IW-1:0]        res_idx;
    logic [1:0]           res_status;
    cell_op_t             res_op;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // number of cells the carry chain must cover
    always_comb
    begin
        case (req.action)
            ACT_DELETE, ACT_READ:
                scan_n = (req.position < count_reg) ? req.position + PW'(1) : '0;
            ACT_FIND:
                scan_n = count_reg;
            default:
                scan_n = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = (scan_n != '0) ? ST_SCAN : ST_DONE;
            ST_SCAN: if (left_reg == PW'(1)) state_next = ST_DONE;
            ST_DONE: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_word   = '0;
        res_idx    = '0;
        res_status = STAT_OK;
        res_op     = CELL_HOLD;
        count_next = count_reg;
        case (act_reg)
            ACT_APPEND:
            begin
                if (count_reg >= FULL_COUNT)
                    res_status = STAT_FULL;
                else
                begin
                    res_op     = CELL_INSERT;
                    count_next = count_reg + PW'(1);
                end
            end
            ACT_INSERT:
            begin
                if (pos_reg > count_reg)
                    res_status = STAT_RANGE;
                else if (count_reg >= FULL_COUNT)
                    res_status = STAT_FULL;
                else
                begin
                    res_op     = CELL_INSERT;
                    count_next = count_reg + PW'(1);
                end
            end
            ACT_DELETE:
            begin
                if (pos_reg >= count_reg)
                    res_status = STAT_RANGE;
                else
                begin
                    res_word   = carry_word;
                    res_op     = CELL_DELETE;
                    count_next = count_reg - PW'(1);
                end
            end
            ACT_READ:
            begin
                if (pos_reg >= count_reg)
                    res_status = STAT_RANGE;
                else
                    res_word = carry_word;
            end
            ACT_FIND:
            begin
                if (carry_hit)
                    res_idx = carry_idx;
                else
                    res_status = STAT_NOT_FOUND;
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
        if (!commit)
        begin
            res_op     = CELL_HOLD;
            count_next = count_reg;
        end
    end

    // append is an insert at the current end
    assign cell_pos  = (act_reg == ACT_APPEND) ? count_reg : pos_reg;
    assign cell_word = word_reg;
    assign cmd.op    = res_op;
    assign cmd.clear = accept;
    assign cmd.scan  = (state_reg == ST_SCAN);
    assign cmd.find  = (act_reg == ACT_FIND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (accept)
                left_reg <= scan_n;
            else if (state_reg == ST_SCAN)
                left_reg <= left_reg - PW'(1);
            if (commit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= req.action;
            pos_reg  <= req.position;
            word_reg <= req.word_in;
        end
        if (commit)
        begin
            out_word_reg   <= res_word;
            out_idx_reg    <= res_idx;
            out_len_reg    <= count_next;
            out_status_reg <= res_status;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.word_out    = out_word_reg;
    assign rsp.found_index = out_idx_reg;
    assign rsp.length      = out_len_reg;
    assign rsp.status      = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("list length above capacity");

    a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (left_reg != '0))
        else $error("scan running with no cells left");

    a_delete_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && act_reg == ACT_DELETE && pos_reg < count_reg)
        |-> carry_hit)
        else $error("delete of a valid entry found no carry");

    a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DONE) |=> (count_reg == $past(count_reg)))
        else $error("length changed outside commit");
`endif

endmodule

`default_nettype wire

@@ test/olist_checker.sv @@
// Ordered list engine testbench: request/response checker with its own list predictor.
// Depends on olist_pkg and the channel interfaces in olist_ifs.sv.
`default_nettype none

module olist_checker
    import olist_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    olist_req_if      req,
    olist_rsp_if      rsp,
    output int        mismatches,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [5:0]           index;
        logic [6:0]           length;
        logic [1:0]           status;
    } list_result_t;

    logic [WORD_BITS-1:0] shadow_entries [DEPTH];
    int                   shadow_len;
    list_result_t         owed_results [$];

    // one request against the shadow list; returns the response it must produce
    task automatic apply_list_op(
        input  logic [2:0]           act,
        input  logic [6:0]           pos,
        input  logic [WORD_BITS-1:0] word,
        output list_result_t         res
    );
        int p;
        p = int'(pos);
        res = '0;
        res.status = STAT_OK;
        case (act)
            ACT_APPEND:
                if (shadow_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    shadow_entries[shadow_len] = word;
                    shadow_len++;
                end
            ACT_INSERT:
                if (p > shadow_len) begin
                    res.status = STAT_RANGE;
                end else if (shadow_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = word;
                    shadow_len++;
                end
            ACT_DELETE:
                if (p >= shadow_len) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.word = shadow_entries[p];
                    for (int i = p; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_entries[shadow_len-1] = '0;
                    shadow_len--;
                end
            ACT_READ:
                if (p >= shadow_len)
                    res.status = STAT_RANGE;
                else
                    res.word = shadow_entries[p];
            ACT_FIND:
            begin
                res.status = STAT_NOT_FOUND;
                for (int i = 0; i < shadow_len && res.status == STAT_NOT_FOUND; i++) begin
                    if (shadow_entries[i] == word) begin
                        res.index  = 6'(i);
                        res.status = STAT_OK;
                    end
                end
            end
            default: ;  // spare codes leave the list alone
        endcase
        res.length = 7'(shadow_len);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        list_result_t want;
        list_result_t res;
        if (!rst_n) begin
            shadow_len = 0;
            owed_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            // responses first: a request accepted at this edge cannot answer yet
            if (rsp.valid && rsp.ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unrequested response, expected none, actual %h %0d %0d %0d",
                             $time, rsp.word_out, rsp.found_index, rsp.length, rsp.status);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("word_out",    64'(want.word),   64'(rsp.word_out));
                    check_field("found_index", 64'(want.index),  64'(rsp.found_index));
                    check_field("length",      64'(want.length), 64'(rsp.length));
                    check_field("status",      64'(want.status), 64'(rsp.status));
                end
            end
            if (req.valid && req.ready) begin
                apply_list_op(req.action, req.position, req.word_in, res);
                owed_results.push_back(res);
            end
            outstanding = owed_results.size();
        end
    end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Ordered list engine testbench top: clock, reset, request stimulus, response drain, verdict.
// Depends on olist_pkg, olist_ifs.sv, olist_checker and ordered_list_engine_top.
`default_nettype none

module tb_top
    import olist_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int RANDOM_REQUESTS = 2000;

    // action codes the block must ignore
    localparam logic [2:0] ACT_SPARE_LO = ACT_FIND + 3'd1;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    // sender-side view of the list length, used only to aim positions
    int   list_len = 0;
    bit   sender_idles = 1'b1;

    olist_req_if #(.PW(7), .WORD_BITS(WORD_BITS))           req_ch ();
    olist_rsp_if #(.IW(6), .PW(7), .WORD_BITS(WORD_BITS))   rsp_ch ();

    ordered_list_engine_top #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    olist_checker #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (fail_count),
        .outstanding (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one request and hold it until the block takes it. An optional
    // gap comes first; valid stays high between back-to-back requests so it
    // never sees two assignments in one step.
    task automatic send_request(
        input logic [2:0]           act,
        input logic [6:0]           pos,
        input logic [WORD_BITS-1:0] word
    );
        if (sender_idles && $urandom_range(99) < 28) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.word_in  <= word;
        do @(posedge clk); while (!req_ch.ready);
        case (act)
            ACT_APPEND: if (list_len < DEPTH) list_len++;
            ACT_INSERT: if (pos <= list_len && list_len < DEPTH) list_len++;
            ACT_DELETE: if (pos < list_len) list_len--;
            default: ;
        endcase
    endtask

    // Grow phases lean on append/insert so the list fills and hits full;
    // shrink phases lean on delete so it drains down to empty.
    // Words mostly come from a small pool so finds hit and duplicates occur.
    task automatic random_request(input bit grow);
        int                   roll;
        logic [2:0]           act;
        logic [6:0]           pos;
        logic [WORD_BITS-1:0] word;
        roll = $urandom_range(99);
        if (grow) begin
            if      (roll < 35) act = ACT_APPEND;
            else if (roll < 70) act = ACT_INSERT;
            else if (roll < 78) act = ACT_DELETE;
            else if (roll < 88) act = ACT_READ;
            else if (roll < 96) act = ACT_FIND;
            else                act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end else begin
            if      (roll < 5)  act = ACT_APPEND;
            else if (roll < 10) act = ACT_INSERT;
            else if (roll < 70) act = ACT_DELETE;
            else if (roll < 82) act = ACT_READ;
            else if (roll < 96) act = ACT_FIND;
            else                act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        // mostly in range or one past the end, sometimes anywhere in 7 bits
        if ($urandom_range(9) < 8)
            pos = 7'($urandom_range(0, list_len));
        else
            pos = 7'($urandom_range(0, 127));
        if ($urandom_range(3) == 0)
            word = $urandom;
        else
            word = WORD_BITS'($urandom_range(0, 15));
        send_request(act, pos, word);
    endtask

    initial begin : stimulus
        req_ch.valid    <= 1'b0;
        req_ch.action   <= ACT_APPEND;
        req_ch.position <= '0;
        req_ch.word_in  <= '0;
        rst_n           <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: empty-list errors ---
        send_request(ACT_READ,   7'd0, 32'h0);
        send_request(ACT_DELETE, 7'd0, 32'h0);
        send_request(ACT_FIND,   7'd0, 32'h0);
        send_request(ACT_INSERT, 7'd1, 32'h1111_1111);   // past the end
        // --- build a short list: insert into empty, append, insert at the end, at the head ---
        send_request(ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_request(ACT_APPEND, 7'd0, 32'h0000_0000);
        send_request(ACT_INSERT, 7'd2, 32'h1234_5678);
        send_request(ACT_INSERT, 7'd0, 32'hA5A5_A5A5);
        // --- reads, including just past the end and the widest positions; out-of-range delete and insert ---
        send_request(ACT_READ,   7'd3,   32'h0);
        send_request(ACT_READ,   7'd4,   32'h0);
        send_request(ACT_READ,   7'd127, 32'h0);
        send_request(ACT_DELETE, 7'd64,  32'h0);
        send_request(ACT_INSERT, 7'd127, 32'h5A5A_5A5A);
        // --- finds: zero word, all-ones word, a miss ---
        send_request(ACT_FIND,   7'd0, 32'h0000_0000);
        send_request(ACT_FIND,   7'd0, 32'hFFFF_FFFF);
        send_request(ACT_FIND,   7'd0, 32'hDEAD_BEEF);
        // --- deletes in the middle and at the tail ---
        send_request(ACT_DELETE, 7'd1, 32'h0);
        send_request(ACT_DELETE, 7'(list_len - 1), 32'h0);
        // --- spare action codes with busy fields ---
        send_request(ACT_SPARE_LO,        7'd0,   32'hFFFF_FFFF);
        send_request(ACT_SPARE_LO + 3'd1, 7'd127, 32'h8000_0001);
        send_request(ACT_SPARE_HI,        7'd64,  32'h0000_0000);
        send_request(ACT_APPEND, 7'd127, 32'h8000_0000);
        send_request(ACT_FIND,   7'd0,   32'h8000_0000);

        // --- random: alternating grow and shrink phases ---
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            sender_idles = !(n >= 1200 && n < 1500);
            if (n == RANDOM_REQUESTS / 2) begin
                // pause until the block has answered everything; wait on the clock
                // first so the checker has counted the last accepted request
                req_ch.valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            random_request((n / 150) % 2 == 0);
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Response side: random stalls, one long hold-off that backs the block up
    // into its request port, and one long stretch always ready.
    initial begin : rsp_drain
        int cyc;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        cyc = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc >= 3000 && cyc < 3300)
                rsp_ch.ready <= 1'b0;
            else if (cyc >= 6000 && cyc < 9000)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 28);
        end
    end

    initial begin : watchdog
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
